// ===== rtl/core/slex_pkg.sv =====
// slex_pkg: shared types and constants for the S-expression lexer.
// No dependencies; imported by s_expression_lexer, slex_token_checker and tb.
`default_nettype none

package slex_pkg;

  // Token kind codes carried on the result channel
  typedef enum logic [2:0] {
    KIND_OPEN   = 3'd0,
    KIND_CLOSE  = 3'd1,
    KIND_QUOTE  = 3'd2,
    KIND_STRING = 3'd3,
    KIND_SYMBOL = 3'd4
  } kind_e;

  localparam logic [7:0] CH_SEMI   = 8'h3B;  // ';'
  localparam logic [7:0] CH_OPEN   = 8'h28;  // '('
  localparam logic [7:0] CH_CLOSE  = 8'h29;  // ')'
  localparam logic [7:0] CH_DQUOTE = 8'h22;  // '"'
  localparam logic [7:0] CH_QUOTE  = 8'h27;  // '\''
  localparam logic [7:0] CH_BSLASH = 8'h5C;  // '\\'
  localparam logic [7:0] CH_NL     = 8'h0A;

  // One result item
  typedef struct packed {
    logic [7:0] ch;
    kind_e      kind;
    logic       is_char;
    logic       starts;
    logic       ends;
    logic       unterm;
    logic       last;
  } lex_item_t;

  // Space, tab, newline, vertical tab, form feed, carriage return
  function automatic logic is_ws(input logic [7:0] c);
    return c inside {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
  endfunction

  function automatic lex_item_t mk_item(input logic [7:0] ch, input kind_e kind,
                                        input logic is_char, input logic starts,
                                        input logic ends, input logic unterm);
    lex_item_t it;
    it.ch      = ch;
    it.kind    = kind;
    it.is_char = is_char;
    it.starts  = starts;
    it.ends    = ends;
    it.unterm  = unterm;
    it.last    = 1'b0;
    return it;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/s_expression_lexer.sv =====
// s_expression_lexer: streaming tokenizer for Lisp source, one byte per transaction.
// Depends on slex_pkg (kind codes, item struct, whitespace test).
//
//  Channel  Dir  Signals                      Contents
//  s_axis   in   tvalid/tready/tdata/tlast    tdata[7:0] char_in; tlast end_of_input
//  m_axis   out  tvalid/tready/tdata/tuser/   tdata[7:0] char_out; tuser kind, is_char,
//                tlast                        starts_token, ends_token, unterminated;
//                                             tlast last result of an input byte
//
// Cycles: the lexer decodes a byte in the cycle it is accepted and writes its
// zero, one or two result items into a four-entry result queue. A byte is taken
// whenever the queue has room for two items, so one byte per cycle is sustained
// while the sink keeps up; a symbol ended by a parenthesis yields two items and
// gives the sink one extra item to take. Reset clears the lexer state (between tokens)
// and empties the queue. A stalled sink fills the queue and then holds off input.
`default_nettype none

module s_expression_lexer
  import slex_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // input byte stream
  input  wire logic       s_axis_tvalid_i,
  output      logic       s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // [7:0] char_in
  input  wire logic       s_axis_tlast_i,   // end_of_input
  // token character stream
  output      logic       m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output      logic [7:0] m_axis_tdata_o,   // [7:0] char_out
  output      logic [7:0] m_axis_tuser_o,   // [2:0] kind, [3] is_char, [4] starts_token,
                                            // [5] ends_token, [6] unterminated, [7] zero
  output      logic       m_axis_tlast_o    // last
);

  typedef enum logic [1:0] {
    MODE_BETWEEN = 2'd0,
    MODE_COMMENT = 2'd1,
    MODE_STRING  = 2'd2,
    MODE_SYMBOL  = 2'd3
  } mode_e;

  localparam int unsigned QDepth = 4;
  localparam int unsigned PtrW   = $clog2(QDepth);
  localparam int unsigned CntW   = $clog2(QDepth + 1);

  mode_e            mode_q, mode_d;
  logic             bs_q, bs_d;          // previous string byte was a backslash
  lex_item_t        queue_q [QDepth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;

  logic       s_accept, m_accept, eoi;
  logic [7:0] c;
  logic [1:0] n_items;
  lex_item_t  item0, item1;

  // between-token decode of the current byte
  logic       bt_valid;
  lex_item_t  bt_item;
  mode_e      bt_mode;

  assign c        = s_axis_tdata_i;
  assign eoi      = s_axis_tlast_i;
  assign s_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign m_accept = m_axis_tvalid_o && m_axis_tready_i;

  // room for the two-item worst case
  assign s_axis_tready_o = (count_q <= CntW'(QDepth - 2));

  always_comb begin
    bt_valid = 1'b0;
    bt_item  = mk_item(c, KIND_SYMBOL, 1'b1, 1'b1, 1'b0, 1'b0);
    bt_mode  = MODE_BETWEEN;
    if (is_ws(c)) begin
      bt_valid = 1'b0;
    end else if (c == CH_SEMI) begin
      bt_mode = MODE_COMMENT;
    end else if (c == CH_OPEN) begin
      bt_valid = 1'b1;
      bt_item  = mk_item(c, KIND_OPEN, 1'b1, 1'b1, 1'b1, 1'b0);
    end else if (c == CH_CLOSE) begin
      bt_valid = 1'b1;
      bt_item  = mk_item(c, KIND_CLOSE, 1'b1, 1'b1, 1'b1, 1'b0);
    end else if (c == CH_QUOTE) begin
      bt_valid = 1'b1;
      bt_item  = mk_item(c, KIND_QUOTE, 1'b1, 1'b1, 1'b1, 1'b0);
    end else if (c == CH_DQUOTE) begin
      bt_valid = 1'b1;
      bt_item  = mk_item(c, KIND_STRING, 1'b1, 1'b1, 1'b0, 1'b0);
      bt_mode  = MODE_STRING;
    end else begin
      bt_valid = 1'b1;
      bt_mode  = MODE_SYMBOL;
    end
  end

  // main decode: up to two items per byte
  always_comb begin
    logic closes;
    closes  = (c == CH_DQUOTE) && !bs_q;
    n_items = 2'd0;
    item0   = bt_item;
    item1   = bt_item;
    mode_d  = mode_q;
    bs_d    = bs_q;
    if (eoi) begin
      // close whatever token is open
      if (mode_q == MODE_SYMBOL) begin
        n_items = 2'd1;
        item0   = mk_item(8'h00, KIND_SYMBOL, 1'b0, 1'b0, 1'b1, 1'b0);
      end else if (mode_q == MODE_STRING) begin
        n_items = 2'd1;
        item0   = mk_item(8'h00, KIND_STRING, 1'b0, 1'b0, 1'b1, 1'b1);
      end
      mode_d = MODE_BETWEEN;
      bs_d   = 1'b0;
    end else begin
      case (mode_q)
        MODE_COMMENT: begin
          if (c == CH_NL) mode_d = MODE_BETWEEN;
        end
        MODE_STRING: begin
          n_items = 2'd1;
          item0   = mk_item(c, KIND_STRING, 1'b1, 1'b0, closes, 1'b0);
          bs_d    = (c == CH_BSLASH) && !closes;
          if (closes) mode_d = MODE_BETWEEN;
        end
        MODE_SYMBOL: begin
          if (is_ws(c) || c == CH_OPEN || c == CH_CLOSE) begin
            // end marker, then the delimiter itself if it is a token
            item0   = mk_item(8'h00, KIND_SYMBOL, 1'b0, 1'b0, 1'b1, 1'b0);
            item1   = bt_item;
            n_items = bt_valid ? 2'd2 : 2'd1;
            mode_d  = bt_mode;
          end else begin
            n_items = 2'd1;
            item0   = mk_item(c, KIND_SYMBOL, 1'b1, 1'b0, 1'b0, 1'b0);
          end
        end
        default: begin  // between tokens
          n_items = bt_valid ? 2'd1 : 2'd0;
          item0   = bt_item;
          mode_d  = bt_mode;
          bs_d    = 1'b0;
        end
      endcase
    end
    if (n_items == 2'd1) item0.last = 1'b1;
    if (n_items == 2'd2) item1.last = 1'b1;
  end

  // lexer state, queue control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_BETWEEN;
      bs_q     <= 1'b0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      logic [CntW-1:0] push_n;
      push_n = s_accept ? CntW'(n_items) : '0;
      if (s_accept) begin
        mode_q   <= mode_d;
        bs_q     <= bs_d;
        wr_ptr_q <= wr_ptr_q + PtrW'(n_items);
      end
      if (m_accept) rd_ptr_q <= rd_ptr_q + 1'b1;
      count_q <= count_q + push_n - CntW'(m_accept);
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (s_accept && n_items != 2'd0) queue_q[wr_ptr_q] <= item0;
    if (s_accept && n_items == 2'd2) queue_q[wr_ptr_q + 1'b1] <= item1;
  end

  assign m_axis_tvalid_o = (count_q != '0);
  assign m_axis_tdata_o  = queue_q[rd_ptr_q].ch;
  assign m_axis_tuser_o  = {1'b0, queue_q[rd_ptr_q].unterm, queue_q[rd_ptr_q].ends,
                            queue_q[rd_ptr_q].starts, queue_q[rd_ptr_q].is_char,
                            queue_q[rd_ptr_q].kind};
  assign m_axis_tlast_o  = queue_q[rd_ptr_q].last;

  // ---------------------------------------------------------------------------
  // Assertions
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QDepth))
    else $error("result queue overflow");

  a_bs_in_string: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bs_q |-> mode_q == MODE_STRING)
    else $error("backslash mark set outside a string");

  a_eoi_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept && eoi |=> mode_q == MODE_BETWEEN && !bs_q)
    else $error("end of input did not return lexer to between tokens");

  a_unterm_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[6] |-> !m_axis_tuser_o[3] && m_axis_tlast_o)
    else $error("unterminated flag on a character item");

endmodule

`default_nettype wire

// ===== sim/slex_token_checker.sv =====
// slex_token_checker: predicts the token stream of s_expression_lexer and scores it.
// Depends on slex_pkg (kind_e, lex_item_t); instantiated beside the DUT by tb.
`timescale 1ns / 100ps

module slex_token_checker
  import slex_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_tvalid_i,
  input  wire logic       s_tready_i,
  input  wire logic [7:0] s_tdata_i,   // [7:0] char_in
  input  wire logic       s_tlast_i,   // end_of_input
  input  wire logic       m_tvalid_i,
  input  wire logic       m_tready_i,
  input  wire logic [7:0] m_tdata_i,   // [7:0] char_out
  input  wire logic [7:0] m_tuser_i,   // [2:0] kind, [3] is_char, [4] starts, [5] ends, [6] unterm
  input  wire logic       m_tlast_i,   // last
  output int              fail_count_o,
  output int              outstanding_o
);

  typedef enum logic [1:0] {
    SCAN_BETWEEN,
    SCAN_COMMENT,
    SCAN_STRING,
    SCAN_SYMBOL
  } scan_mode_e;

  scan_mode_e  scan_mode;
  logic        after_bslash;
  lex_item_t   token_q[$];
  int          mismatches = 0;

  assign fail_count_o = mismatches;

  function automatic lex_item_t token_item(input logic [7:0] ch, input kind_e kind,
                                           input logic is_char, input logic starts,
                                           input logic ends, input logic unterm);
    lex_item_t t;
    t = '0;
    t.ch      = ch;
    t.kind    = kind;
    t.is_char = is_char;
    t.starts  = starts;
    t.ends    = ends;
    t.unterm  = unterm;
    return t;
  endfunction

  // Advance the lexer state by one source byte and queue the tokens it yields
  task automatic lex_byte(input logic [7:0] c, input logic eoi);
    lex_item_t out_items[2];
    int        n;
    logic      blank;
    n     = 0;
    blank = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    if (eoi) begin
      // end of text closes whatever is open; comments just vanish
      if (scan_mode == SCAN_SYMBOL) begin
        out_items[n] = token_item(8'h00, KIND_SYMBOL, 1'b0, 1'b0, 1'b1, 1'b0);
        n = n + 1;
      end else if (scan_mode == SCAN_STRING) begin
        out_items[n] = token_item(8'h00, KIND_STRING, 1'b0, 1'b0, 1'b1, 1'b1);
        n = n + 1;
      end
      scan_mode    = SCAN_BETWEEN;
      after_bslash = 1'b0;
    end else if (scan_mode == SCAN_COMMENT) begin
      if (c == CH_NL) scan_mode = SCAN_BETWEEN;
    end else if (scan_mode == SCAN_STRING) begin
      out_items[n] = token_item(c, KIND_STRING, 1'b1, 1'b0,
                                (c == CH_DQUOTE) && !after_bslash, 1'b0);
      n = n + 1;
      if (c == CH_DQUOTE && !after_bslash) begin
        scan_mode    = SCAN_BETWEEN;
        after_bslash = 1'b0;
      end else begin
        after_bslash = (c == CH_BSLASH);
      end
    end else begin
      if (scan_mode == SCAN_SYMBOL) begin
        if (blank || c == CH_OPEN || c == CH_CLOSE) begin
          // delimiter seen only now: close the symbol with an end marker
          out_items[n] = token_item(8'h00, KIND_SYMBOL, 1'b0, 1'b0, 1'b1, 1'b0);
          n = n + 1;
          scan_mode = SCAN_BETWEEN;
        end else begin
          out_items[n] = token_item(c, KIND_SYMBOL, 1'b1, 1'b0, 1'b0, 1'b0);
          n = n + 1;
        end
      end
      if (scan_mode == SCAN_BETWEEN && !blank) begin
        case (c)
          CH_SEMI: scan_mode = SCAN_COMMENT;
          CH_OPEN: begin
            out_items[n] = token_item(c, KIND_OPEN, 1'b1, 1'b1, 1'b1, 1'b0);
            n = n + 1;
          end
          CH_CLOSE: begin
            out_items[n] = token_item(c, KIND_CLOSE, 1'b1, 1'b1, 1'b1, 1'b0);
            n = n + 1;
          end
          CH_QUOTE: begin
            out_items[n] = token_item(c, KIND_QUOTE, 1'b1, 1'b1, 1'b1, 1'b0);
            n = n + 1;
          end
          CH_DQUOTE: begin
            out_items[n] = token_item(c, KIND_STRING, 1'b1, 1'b1, 1'b0, 1'b0);
            n = n + 1;
            scan_mode    = SCAN_STRING;
            after_bslash = 1'b0;
          end
          default: begin
            out_items[n] = token_item(c, KIND_SYMBOL, 1'b1, 1'b1, 1'b0, 1'b0);
            n = n + 1;
            scan_mode = SCAN_SYMBOL;
          end
        endcase
      end
    end
    for (int k = 0; k < n; k++) begin
      out_items[k].last = (k == n - 1);
      token_q.push_back(out_items[k]);
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches = mismatches + 1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    lex_item_t want;
    if (!rst_ni) begin
      scan_mode     = SCAN_BETWEEN;
      after_bslash  = 1'b0;
      token_q.delete();
      outstanding_o <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (token_q.size() == 0) begin
          $error("token with nothing expected: char %0h, tuser %0h", m_tdata_i, m_tuser_i);
          mismatches = mismatches + 1;
        end else begin
          want = token_q.pop_front();
          check_field("char_out", want.ch, m_tdata_i);
          check_field("kind", {5'd0, want.kind}, {5'd0, m_tuser_i[2:0]});
          check_field("is_char", {7'd0, want.is_char}, {7'd0, m_tuser_i[3]});
          check_field("starts_token", {7'd0, want.starts}, {7'd0, m_tuser_i[4]});
          check_field("ends_token", {7'd0, want.ends}, {7'd0, m_tuser_i[5]});
          check_field("unterminated", {7'd0, want.unterm}, {7'd0, m_tuser_i[6]});
          check_field("last", {7'd0, want.last}, {7'd0, m_tlast_i});
        end
      end
      if (s_tvalid_i && s_tready_i) lex_byte(s_tdata_i, s_tlast_i);
      outstanding_o <= token_q.size();
    end
  end

endmodule

// ===== sim/tb.sv =====
// tb: stimulus and verdict for s_expression_lexer; slex_token_checker does the scoring.
// Depends on slex_pkg, s_expression_lexer and slex_token_checker.
`timescale 1ns / 100ps

module tb;
  import slex_pkg::*;

  localparam int RANDOM_BYTES = 600;
  localparam int QUIET_TAIL   = 100;   // final transactions with no idling
  localparam int HOLD_AT      = 150;   // sink stalls for a long stretch here
  localparam int HOLD_CYCLES  = 40;
  localparam int DRAIN_AT     = 300;   // source waits for an empty pipe here
  localparam int IDLE_LIMIT   = 1000;  // cycles without any transaction

  typedef struct {
    logic [7:0] c;
    logic       eoi;
  } src_byte_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_tvalid = 1'b0;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tlast = 1'b0;
  logic       m_tready = 1'b0;
  wire        s_tready;
  wire        m_tvalid;
  wire  [7:0] m_tdata;
  wire  [7:0] m_tuser;
  wire        m_tlast;

  int         fail_count;
  int         outstanding;
  int         sent_cnt = 0;
  int         idle_cycles = 0;
  logic       quiet = 1'b0;
  src_byte_t  source_text[$];

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  s_expression_lexer DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  slex_token_checker scoreboard (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_tvalid_i    (s_tvalid),
    .s_tready_i    (s_tready),
    .s_tdata_i     (s_tdata),
    .s_tlast_i     (s_tlast),
    .m_tvalid_i    (m_tvalid),
    .m_tready_i    (m_tready),
    .m_tdata_i     (m_tdata),
    .m_tuser_i     (m_tuser),
    .m_tlast_i     (m_tlast),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  // ---------------------------------------------------------------------------
  // Source text construction
  // ---------------------------------------------------------------------------
  task automatic put(input logic [7:0] c, input logic eoi = 1'b0);
    src_byte_t b;
    b.c   = c;
    b.eoi = eoi;
    source_text.push_back(b);
  endtask

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 5))
      0:       return 8'h20;
      1:       return 8'h09;
      2:       return CH_NL;
      3:       return 8'h0B;
      4:       return 8'h0C;
      default: return 8'h0D;
    endcase
  endfunction

  // A byte that keeps a symbol going; the opener must also not start
  // a comment, a string or a quote token.
  function automatic logic [7:0] pick_sym_byte(input logic opener);
    logic [7:0] b;
    logic       ok;
    ok = 1'b0;
    while (!ok) begin
      b  = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(8'h61, 8'h7A))
                                       : 8'($urandom_range(0, 255));
      ok = !((b >= 8'h09 && b <= 8'h0D) || b == 8'h20 || b == CH_OPEN || b == CH_CLOSE);
      if (opener && (b == CH_SEMI || b == CH_DQUOTE || b == CH_QUOTE)) ok = 1'b0;
    end
    return b;
  endfunction

  // Mostly well-formed tokens with random content, plus raw noise and
  // end-of-text marks dropped in mid-token.
  task automatic add_random_text(input int n_bytes);
    int stop_at;
    int sel;
    int len;
    stop_at = source_text.size() + n_bytes;
    while (source_text.size() < stop_at) begin
      sel = $urandom_range(0, 99);
      if (sel < 30) begin
        len = $urandom_range(1, 6);
        put(pick_sym_byte(1'b1));
        for (int k = 1; k < len; k++) put(pick_sym_byte(1'b0));
      end else if (sel < 45) begin
        put(CH_DQUOTE);
        len = $urandom_range(0, 8);
        for (int k = 0; k < len; k++) begin
          case ($urandom_range(0, 9))
            0, 1: put(CH_BSLASH);
            2: begin
              put(CH_BSLASH);
              put(CH_DQUOTE);
            end
            default: put(8'($urandom_range(0, 255)));
          endcase
        end
        put(CH_DQUOTE);
      end else if (sel < 53) begin
        put(CH_SEMI);
        len = $urandom_range(0, 6);
        for (int k = 0; k < len; k++) begin
          logic [7:0] b;
          b = 8'($urandom_range(0, 255));
          put((b == CH_NL) ? 8'h00 : b);
        end
        put(CH_NL);
      end else if (sel < 68) begin
        case ($urandom_range(0, 2))
          0:       put(CH_OPEN);
          1:       put(CH_CLOSE);
          default: put(CH_QUOTE);
        endcase
      end else if (sel < 83) begin
        put(pick_blank());
      end else if (sel < 93) begin
        put(8'($urandom_range(0, 255)));
      end else begin
        put(8'($urandom_range(0, 255)), 1'b1);
      end
    end
  endtask

  task automatic add_directed_text();
    put(CH_OPEN);
    put(CH_CLOSE);
    put(CH_QUOTE);
    put(8'h61);             // 'a' opens a symbol
    put(8'h00);             // zero byte is an ordinary symbol char
    put(CH_SEMI);           // ';' and quote inside a symbol stay in it
    put(CH_QUOTE);
    put(CH_CLOSE);          // symbol end marker plus close paren
    put(8'h79);             // 'y'
    put(8'h09);             // tab ends the symbol
    put(8'h78);             // 'x'
    put(CH_OPEN);           // end marker plus open paren
    put(CH_SEMI);           // comment swallows the paren
    put(CH_OPEN);
    put(CH_NL);
    put(CH_DQUOTE);
    put(CH_BSLASH);
    put(CH_DQUOTE);         // escaped, string goes on
    put(CH_BSLASH);
    put(CH_BSLASH);
    put(CH_DQUOTE);         // second backslash still escapes
    put(CH_DQUOTE);         // closes the string
    put(CH_DQUOTE);
    put(8'hFF, 1'b1);       // end of text inside a string, char ignored
    put(8'h7A);             // 'z'
    put(8'h00, 1'b1);       // end of text inside a symbol
    put(8'h00, 1'b1);       // end of text between tokens
    put(CH_SEMI);
    put(8'hFF, 1'b1);       // end of text inside a comment
  endtask

  // ---------------------------------------------------------------------------
  // Source side: one transaction per byte, random gaps, one full drain pause
  // ---------------------------------------------------------------------------
  initial begin
    int total;
    add_directed_text();
    add_random_text(RANDOM_BYTES);
    total = source_text.size();

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < total; i++) begin
      if (i >= total - QUIET_TAIL) quiet = 1'b1;
      if (i == DRAIN_AT) begin
        // let every pending token come out before the next byte
        s_tvalid <= 1'b0;
        do @(posedge clk_i); while (outstanding != 0);
      end
      if (!quiet && ((i / 64) % 2 == 0) && $urandom_range(0, 5) == 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
      s_tvalid <= 1'b1;
      s_tdata  <= source_text[i].c;
      s_tlast  <= source_text[i].eoi;
      @(posedge clk_i);
      while (!s_tready) @(posedge clk_i);
      sent_cnt <= sent_cnt + 1;
    end
    s_tvalid <= 1'b0;

    do @(posedge clk_i); while (outstanding != 0);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sink side: random stall bursts, one long hold-off to back up the queue
  // ---------------------------------------------------------------------------
  initial begin
    int   stall_left;
    logic held;
    stall_left = 0;
    held       = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left = stall_left - 1;
        m_tready <= 1'b0;
      end else if (!held && sent_cnt >= HOLD_AT) begin
        held       = 1'b1;
        stall_left = HOLD_CYCLES - 1;
        m_tready <= 1'b0;
      end else if (!quiet && ((sent_cnt / 64) % 3 != 2) && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 5);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog: a run that stops moving is a failure
  always @(posedge clk_i) begin
    if (!rst_ni || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
